@@ design/qrm_pkg.sv @@
// Package for the quaternion to rotation matrix converter.
// Holds the default widths and the matrix entry indexes; no dependencies.
package qrm_pkg;

  localparam int COMPONENT_BITS_DEF = 16;
  localparam int FRACTION_BITS_DEF  = 14;
  localparam int NUM_ENTRIES        = 9;

  localparam int IDX_M00 = 0;
  localparam int IDX_M01 = 1;
  localparam int IDX_M02 = 2;
  localparam int IDX_M10 = 3;
  localparam int IDX_M11 = 4;
  localparam int IDX_M12 = 5;
  localparam int IDX_M20 = 6;
  localparam int IDX_M21 = 7;
  localparam int IDX_M22 = 8;

endpackage

@@ design/qrm_if.sv @@
// Valid/ready channel interfaces for the quaternion input and the matrix output.
// Depends on nothing; widths come from the interface parameters.
interface qrm_quat_if #(parameter int COMPONENT_BITS = 16);
  logic                             valid;
  logic                             ready;
  logic signed [COMPONENT_BITS-1:0] q_w;
  logic signed [COMPONENT_BITS-1:0] q_x;
  logic signed [COMPONENT_BITS-1:0] q_y;
  logic signed [COMPONENT_BITS-1:0] q_z;

  modport source (output valid, q_w, q_x, q_y, q_z, input ready);
  modport sink (input valid, q_w, q_x, q_y, q_z, output ready);
endinterface

interface qrm_mat_if #(parameter int RESULT_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [RESULT_BITS-1:0] m00;
  logic signed [RESULT_BITS-1:0] m01;
  logic signed [RESULT_BITS-1:0] m02;
  logic signed [RESULT_BITS-1:0] m10;
  logic signed [RESULT_BITS-1:0] m11;
  logic signed [RESULT_BITS-1:0] m12;
  logic signed [RESULT_BITS-1:0] m20;
  logic signed [RESULT_BITS-1:0] m21;
  logic signed [RESULT_BITS-1:0] m22;
  logic                          zero_error;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, zero_error,
                  input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, zero_error,
                output ready);
endinterface

@@ design/qrm_products.sv @@
// Front end: products of the components, then the norm and the nine numerators.
// Depends on qrm_pkg; two register stages.
module qrm_products
  import qrm_pkg::*;
#(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
  parameter int NW             = 2 * COMPONENT_BITS + 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic signed [COMPONENT_BITS-1:0] w,
  input  logic signed [COMPONENT_BITS-1:0] x,
  input  logic signed [COMPONENT_BITS-1:0] y,
  input  logic signed [COMPONENT_BITS-1:0] z,
  output logic                             out_valid,
  output logic                             out_zero,
  output logic [NW-1:0]                    norm,
  output logic [NW-1:0]                    mag [NUM_ENTRIES],
  output logic                             neg [NUM_ENTRIES]
);

  localparam int PW = 2 * COMPONENT_BITS;
  localparam int SW = PW + 2;

  logic                 valid1;
  logic                 zero1;
  logic signed [PW-1:0] w2, x2, y2, z2, xy, wz, xz, wy, yz, wx;

  logic signed [SW-1:0] ew2, ex2, ey2, ez2, exy, ewz, exz, ewy, eyz, ewx;
  logic signed [SW-1:0] num [NUM_ENTRIES];
  logic        [SW-1:0] abs_val [NUM_ENTRIES];
  logic        [NW-1:0] mag_next [NUM_ENTRIES];
  logic        [NW-1:0] norm_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (en) begin
      valid1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero1 <= (w == '0) && (x == '0) && (y == '0) && (z == '0);
      w2    <= w * w;
      x2    <= x * x;
      y2    <= y * y;
      z2    <= z * z;
      xy    <= x * y;
      wz    <= w * z;
      xz    <= x * z;
      wy    <= w * y;
      yz    <= y * z;
      wx    <= w * x;
    end
  end

  always_comb begin
    ew2 = $signed({{2{w2[PW-1]}}, w2});
    ex2 = $signed({{2{x2[PW-1]}}, x2});
    ey2 = $signed({{2{y2[PW-1]}}, y2});
    ez2 = $signed({{2{z2[PW-1]}}, z2});
    exy = $signed({{2{xy[PW-1]}}, xy});
    ewz = $signed({{2{wz[PW-1]}}, wz});
    exz = $signed({{2{xz[PW-1]}}, xz});
    ewy = $signed({{2{wy[PW-1]}}, wy});
    eyz = $signed({{2{yz[PW-1]}}, yz});
    ewx = $signed({{2{wx[PW-1]}}, wx});

    norm_next = NW'(ew2 + ex2 + ey2 + ez2);

    num[IDX_M00] = (ew2 + ex2) - (ey2 + ez2);
    num[IDX_M01] = exy - ewz;
    num[IDX_M02] = exz + ewy;
    num[IDX_M10] = exy + ewz;
    num[IDX_M11] = (ew2 + ey2) - (ex2 + ez2);
    num[IDX_M12] = eyz - ewx;
    num[IDX_M20] = exz - ewy;
    num[IDX_M21] = eyz + ewx;
    num[IDX_M22] = (ew2 + ez2) - (ex2 + ey2);

    for (int i = 0; i < NUM_ENTRIES; i++) begin
      abs_val[i] = num[i][SW-1] ? SW'(-num[i]) : SW'(num[i]);
      // Off-diagonal entries carry a factor of two.
      if (i == IDX_M00 || i == IDX_M11 || i == IDX_M22) begin
        mag_next[i] = abs_val[i][NW-1:0];
      end else begin
        mag_next[i] = {abs_val[i][NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_zero <= zero1;
      norm     <= norm_next;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        mag[i] <= mag_next[i];
        neg[i] <= num[i][SW-1];
      end
    end
  end

endmodule

@@ design/qrm_div_step.sv @@
// One stage of the restoring divider: one quotient bit for each of the nine entries.
// Depends on qrm_pkg; one register stage.
module qrm_div_step
  import qrm_pkg::*;
#(
  parameter int NW    = 33,
  parameter int QW    = 16,
  parameter bit FIRST = 1'b0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic          in_zero,
  input  logic [NW-1:0] in_norm,
  input  logic [NW-1:0] in_rem [NUM_ENTRIES],
  input  logic [QW-1:0] in_quo [NUM_ENTRIES],
  input  logic          in_neg [NUM_ENTRIES],
  output logic          out_valid,
  output logic          out_zero,
  output logic [NW-1:0] out_norm,
  output logic [NW-1:0] out_rem [NUM_ENTRIES],
  output logic [QW-1:0] out_quo [NUM_ENTRIES],
  output logic          out_neg [NUM_ENTRIES]
);

  logic [NW:0]   trial [NUM_ENTRIES];
  logic          qbit  [NUM_ENTRIES];
  logic [NW:0]   diff  [NUM_ENTRIES];

  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      trial[i] = FIRST ? {1'b0, in_rem[i]} : {in_rem[i], 1'b0};
      qbit[i]  = trial[i] >= {1'b0, in_norm};
      diff[i]  = trial[i] - {1'b0, in_norm};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_zero <= in_zero;
      out_norm <= in_norm;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        out_rem[i] <= qbit[i] ? diff[i][NW-1:0] : trial[i][NW-1:0];
        out_quo[i] <= {in_quo[i][QW-2:0], qbit[i]};
        out_neg[i] <= in_neg[i];
      end
    end
  end

endmodule

@@ design/qrm_round.sv @@
// Output stage: rounds the quotients, applies sign and saturation, holds the result.
// Depends on qrm_pkg; one register stage that drives the output channel.
module qrm_round
  import qrm_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int QW            = FRACTION_BITS + 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic                 in_zero,
  input  logic [QW-1:0]        in_quo [NUM_ENTRIES],
  input  logic                 in_neg [NUM_ENTRIES],
  output logic                 out_valid,
  output logic                 out_zero,
  output logic signed [QW-1:0] entry [NUM_ENTRIES]
);

  localparam logic [QW-1:0] ONE = QW'(1) << FRACTION_BITS;

  logic [QW:0]   rounded [NUM_ENTRIES];
  logic [QW-1:0] sat     [NUM_ENTRIES];
  logic [QW-1:0] entry_next [NUM_ENTRIES];

  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      // The quotient holds one extra fraction bit; half rounds up in magnitude.
      rounded[i] = ({1'b0, in_quo[i]} + (QW + 1)'(1)) >> 1;
      sat[i]     = (rounded[i] > {1'b0, ONE}) ? ONE : rounded[i][QW-1:0];
      if (in_zero) begin
        entry_next[i] = (i == IDX_M00 || i == IDX_M11 || i == IDX_M22) ? ONE : '0;
      end else begin
        entry_next[i] = in_neg[i] ? QW'(-sat[i]) : sat[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_zero <= in_zero;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        entry[i] <= $signed(entry_next[i]);
      end
    end
  end

endmodule

@@ design/quaternion_to_rotation_matrix_top.sv @@
// Top level of the quaternion to rotation matrix converter.
// Depends on qrm_pkg, qrm_if, qrm_products, qrm_div_step and qrm_round.
//
//   Channel  Dir  Interface    Payload
//   quat     in   qrm_quat_if  q_w, q_x, q_y, q_z
//   mat      out  qrm_mat_if   m00..m22, zero_error
//
// One quaternion is taken in every cycle unless a result is not taken; the restoring
// divider computes one quotient bit per stage.
// Reset clears only the valid bits of the stages.
// When a result is not taken, the whole pipeline holds and ready falls.
module quaternion_to_rotation_matrix_top
  import qrm_pkg::*;
#(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
  parameter int FRACTION_BITS  = FRACTION_BITS_DEF
) (
  input logic clk,
  input logic rst,
  qrm_quat_if.sink quat,
  qrm_mat_if.source mat
);

  localparam int NW     = 2 * COMPONENT_BITS + 1;
  localparam int QW     = FRACTION_BITS + 2;
  localparam int STEPS  = FRACTION_BITS + 2;

  logic adv;

  logic          d_valid [STEPS+1];
  logic          d_zero  [STEPS+1];
  logic [NW-1:0] d_norm  [STEPS+1];
  logic [NW-1:0] d_rem   [STEPS+1][NUM_ENTRIES];
  logic [QW-1:0] d_quo   [STEPS+1][NUM_ENTRIES];
  logic          d_neg   [STEPS+1][NUM_ENTRIES];

  logic               o_valid;
  logic               o_zero;
  logic signed [QW-1:0] o_entry [NUM_ENTRIES];

  assign adv        = !o_valid || mat.ready;
  assign quat.ready = adv;

  qrm_products #(
    .COMPONENT_BITS (COMPONENT_BITS),
    .NW             (NW)
  ) u_products (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (quat.valid),
    .w         (quat.q_w),
    .x         (quat.q_x),
    .y         (quat.q_y),
    .z         (quat.q_z),
    .out_valid (d_valid[0]),
    .out_zero  (d_zero[0]),
    .norm      (d_norm[0]),
    .mag       (d_rem[0]),
    .neg       (d_neg[0])
  );

  for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_quo0
    assign d_quo[0][i] = '0;
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_div
    qrm_div_step #(
      .NW    (NW),
      .QW    (QW),
      .FIRST (k == 0)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (d_valid[k]),
      .in_zero   (d_zero[k]),
      .in_norm   (d_norm[k]),
      .in_rem    (d_rem[k]),
      .in_quo    (d_quo[k]),
      .in_neg    (d_neg[k]),
      .out_valid (d_valid[k+1]),
      .out_zero  (d_zero[k+1]),
      .out_norm  (d_norm[k+1]),
      .out_rem   (d_rem[k+1]),
      .out_quo   (d_quo[k+1]),
      .out_neg   (d_neg[k+1])
    );
  end

  qrm_round #(
    .FRACTION_BITS (FRACTION_BITS),
    .QW            (QW)
  ) u_round (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (d_valid[STEPS]),
    .in_zero   (d_zero[STEPS]),
    .in_quo    (d_quo[STEPS]),
    .in_neg    (d_neg[STEPS]),
    .out_valid (o_valid),
    .out_zero  (o_zero),
    .entry     (o_entry)
  );

  assign mat.valid      = o_valid;
  assign mat.zero_error = o_zero;
  assign mat.m00        = o_entry[IDX_M00];
  assign mat.m01        = o_entry[IDX_M01];
  assign mat.m02        = o_entry[IDX_M02];
  assign mat.m10        = o_entry[IDX_M10];
  assign mat.m11        = o_entry[IDX_M11];
  assign mat.m12        = o_entry[IDX_M12];
  assign mat.m20        = o_entry[IDX_M20];
  assign mat.m21        = o_entry[IDX_M21];
  assign mat.m22        = o_entry[IDX_M22];

endmodule

@@ bench/tb_quaternion_to_rotation_matrix_top.sv @@
// Testbench for the quaternion to rotation matrix converter: random and corner quaternions
// are sent over the input channel and each matrix is checked against an exact predictor.
// Depends on qrm_pkg, qrm_if and quaternion_to_rotation_matrix_top.
`timescale 1ns / 100ps

module tb_quaternion_to_rotation_matrix_top;
  import qrm_pkg::*;

  localparam int CB = COMPONENT_BITS_DEF;
  localparam int FB = FRACTION_BITS_DEF;
  localparam int RB = FB + 2;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef logic signed [CB-1:0] comp_t;
  typedef logic signed [RB-1:0] entry_t;

  typedef struct packed {
    comp_t w;
    comp_t x;
    comp_t y;
    comp_t z;
  } quat_t;

  typedef struct packed {
    entry_t [NUM_ENTRIES-1:0] m;
    logic zero_error;
  } matrix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  qrm_quat_if #(.COMPONENT_BITS(CB)) quat ();
  qrm_mat_if #(.RESULT_BITS(RB)) mat ();

  quaternion_to_rotation_matrix_top #(
    .COMPONENT_BITS(CB),
    .FRACTION_BITS(FB)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .quat(quat),
    .mat(mat)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  quat_t pending_quats[$];
  matrix_t expected_matrices[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_sender = 1'b0;
  int errors = 0;
  int matrices_checked = 0;
  int zero_quats_seen = 0;
  int idle_cycles = 0;

  // Rounded ratio num * 2^steps / den, halves away from zero, saturated to one.
  function automatic entry_t scaled_ratio(longint num, longint den, int steps);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = ((mag <<< (steps + 1)) + den) / (2 * den);
    if (q > (64'sd1 <<< FB)) q = 64'sd1 <<< FB;
    return entry_t'((num < 0) ? -q : q);
  endfunction

  function automatic matrix_t rotation_of(quat_t qi);
    matrix_t r;
    longint w, x, y, z, w2, x2, y2, z2, n;
    w = qi.w;
    x = qi.x;
    y = qi.y;
    z = qi.z;
    r = '0;
    if (w == 0 && x == 0 && y == 0 && z == 0) begin
      r.m[IDX_M00] = entry_t'(1 << FB);
      r.m[IDX_M11] = entry_t'(1 << FB);
      r.m[IDX_M22] = entry_t'(1 << FB);
      r.zero_error = 1'b1;
      return r;
    end
    w2 = w * w;
    x2 = x * x;
    y2 = y * y;
    z2 = z * z;
    n = w2 + x2 + y2 + z2;
    r.m[IDX_M00] = scaled_ratio(w2 + x2 - y2 - z2, n, FB);
    r.m[IDX_M01] = scaled_ratio(x * y - w * z, n, FB + 1);
    r.m[IDX_M02] = scaled_ratio(x * z + w * y, n, FB + 1);
    r.m[IDX_M10] = scaled_ratio(x * y + w * z, n, FB + 1);
    r.m[IDX_M11] = scaled_ratio(w2 - x2 + y2 - z2, n, FB);
    r.m[IDX_M12] = scaled_ratio(y * z - w * x, n, FB + 1);
    r.m[IDX_M20] = scaled_ratio(x * z - w * y, n, FB + 1);
    r.m[IDX_M21] = scaled_ratio(y * z + w * x, n, FB + 1);
    r.m[IDX_M22] = scaled_ratio(w2 - x2 - y2 + z2, n, FB);
    return r;
  endfunction

  function automatic comp_t random_component();
    case ($urandom_range(0, 5))
      0: return comp_t'($urandom_range(0, 8) - 4);
      1: return comp_t'(($urandom & 1) ? 32767 : -32768);
      2: return comp_t'(($urandom_range(0, 255) - 128) << $urandom_range(0, 8));
      default: return comp_t'($urandom);
    endcase
  endfunction

  task automatic queue_quat(int w, int x, int y, int z);
    quat_t qi;
    qi.w = comp_t'(w);
    qi.x = comp_t'(x);
    qi.y = comp_t'(y);
    qi.z = comp_t'(z);
    pending_quats.push_back(qi);
  endtask

  task automatic queue_random(int count);
    quat_t qi;
    for (int i = 0; i < count; i++) begin
      qi.w = random_component();
      qi.x = random_component();
      qi.y = random_component();
      qi.z = random_component();
      if ($urandom_range(0, 40) == 0) qi = '0;
      pending_quats.push_back(qi);
    end
  endtask

  task automatic drain();
    while (pending_quats.size() != 0 || expected_matrices.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      quat.valid <= 1'b0;
    end else if (!quat.valid || quat.ready) begin
      if (pending_quats.size() != 0 && !hold_sender
          && $urandom_range(0, 99) >= send_idle_pct) begin
        quat_t qi;
        qi = pending_quats.pop_front();
        quat.valid <= 1'b1;
        quat.q_w <= qi.w;
        quat.q_x <= qi.x;
        quat.q_y <= qi.y;
        quat.q_z <= qi.z;
        expected_matrices.push_back(rotation_of(qi));
        if (qi == '0) zero_quats_seen++;
      end else begin
        quat.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      mat.ready <= 1'b0;
    end else begin
      mat.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && mat.valid && mat.ready) begin
      matrix_t got;
      matrix_t exp_m;
      got.m[IDX_M00] = mat.m00;
      got.m[IDX_M01] = mat.m01;
      got.m[IDX_M02] = mat.m02;
      got.m[IDX_M10] = mat.m10;
      got.m[IDX_M11] = mat.m11;
      got.m[IDX_M12] = mat.m12;
      got.m[IDX_M20] = mat.m20;
      got.m[IDX_M21] = mat.m21;
      got.m[IDX_M22] = mat.m22;
      got.zero_error = mat.zero_error;
      if (expected_matrices.size() == 0) begin
        $error("matrix transfer with no quaternion outstanding");
        errors++;
      end else begin
        exp_m = expected_matrices.pop_front();
        matrices_checked++;
        for (int k = 0; k < NUM_ENTRIES; k++)
          if (got.m[k] !== exp_m.m[k]) begin
            $error("m%0d%0d: expected %0d, got %0d", k / 3, k % 3, exp_m.m[k], got.m[k]);
            errors++;
          end
        if (got.zero_error !== exp_m.zero_error) begin
          $error("zero_error: expected %0d, got %0d", exp_m.zero_error, got.zero_error);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((quat.valid && quat.ready) || (mat.valid && mat.ready) || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    quat.valid = 1'b0;
    quat.q_w = '0;
    quat.q_x = '0;
    quat.q_y = '0;
    quat.q_z = '0;
    mat.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    queue_quat(0, 0, 0, 0);
    queue_quat(1, 0, 0, 0);
    queue_quat(0, 1, 0, 0);
    queue_quat(0, 0, 1, 0);
    queue_quat(0, 0, 0, 1);
    queue_quat(-32768, 0, 0, 0);
    queue_quat(32767, 32767, 32767, 32767);
    queue_quat(-32768, -32768, -32768, -32768);
    queue_quat(-32768, 32767, -32768, 32767);
    queue_quat(1, 1, 0, 0);
    queue_quat(1, 1, 1, 1);
    queue_quat(3, 1, 0, 0);
    queue_quat(0, 0, 0, -32768);
    queue_quat(16384, 0, 0, -16384);
    queue_quat(-1, -1, -1, -1);
    queue_quat(1, 2, 3, 4);
    queue_quat(-21846, 21845, -1, 12345);
    queue_quat(0, 0, 0, 0);
    queue_quat(32767, -32768, 1, -1);
    queue_quat(2, 0, 0, 0);

    send_idle_pct = 22;
    recv_idle_pct = 63;
    queue_random(350);
    drain();
    hold_sender = 1'b1;
    repeat (FB + 10) @(posedge clk);
    hold_sender = 1'b0;

    send_idle_pct = 63;
    recv_idle_pct = 22;
    queue_random(370);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(380);
    drain();
    repeat (FB + 10) @(posedge clk);

    $display("Checked %0d matrices, %0d from zero quaternions, under three idle patterns.",
             matrices_checked, zero_quats_seen);
    if (errors == 0 && expected_matrices.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
